[sv/ytc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytc_pkg
// Shared types and byte codes for the yaml text cleaner.
// ----------------------------------------------------------------------------
package ytc_pkg;

    localparam int BYTE_W  = 8;
    localparam int FLUSH_W = 6;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    // one unit of work for the output side: flush_n held blanks, then one byte
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [FLUSH_W-1:0] flush_n;
        logic               done;
        logic               ovf;
    } cmd_t;

endpackage

[sv/ytc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ytc_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ytc_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytc_fifo
// Two-entry command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module ytc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ytc_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output ytc_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import ytc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push && !full, pop && !empty})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/ytc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytc_front
// Input classifier: tracks quotes, comments and held blanks, and turns each
// kept byte, and each end of text, into a command for the output sequencer.
// ----------------------------------------------------------------------------
module ytc_front #(
    parameter int PENDING_DEPTH = 32,
    parameter int ADDR_W        = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              back_idle,
    input  logic              q_full,
    output logic              q_push,
    output ytc_pkg::cmd_t     q_cmd,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic              ram_wdata
);
    import ytc_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2D;

    logic [1:0]        quote_reg, quote_next;
    logic              esc_reg, esc_next;
    logic              skip_reg, skip_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic              none_reg, none_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;

    logic [BYTE_W-1:0] c;
    logic [CNT_W-1:0]  cnt_base;
    logic              keep;
    logic              blank;
    logic              room;
    logic              need_write;
    logic              want_push;
    logic              after_sep;
    logic              after_opener;
    logic              accept;

    assign c         = s_tdata;
    assign blank     = (c == CH_SPACE) || (c == CH_TAB);
    assign after_sep = (cnt_reg != '0) || none_reg || (prev_reg == CH_LF);
    assign after_opener = after_sep || (prev_reg == CH_COLON) || (prev_reg == CH_COMMA)
                        || (prev_reg == CH_LBRACK) || (prev_reg == CH_LBRACE)
                        || (prev_reg == CH_DASH);

    always_comb
    begin
        quote_next = quote_reg;
        esc_next   = esc_reg;
        skip_next  = skip_reg;
        prev_next  = prev_reg;
        none_next  = none_reg;
        ovf_next   = ovf_reg;
        cnt_base   = cnt_reg;
        keep       = 1'b0;

        if (s_tlast)
        begin
            quote_next = QUOTE_NONE;
            esc_next   = 1'b0;
            skip_next  = 1'b0;
            prev_next  = '0;
            none_next  = 1'b1;
            cnt_base   = '0;
        end
        else if (quote_reg != QUOTE_NONE)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
            end
            else if ((c == CH_BSLASH) && (quote_reg == QUOTE_DOUBLE))
            begin
                esc_next = 1'b1;
            end
            else if ((c == CH_LF) || ((quote_reg == QUOTE_DOUBLE) && (c == CH_DQUOTE))
                     || ((quote_reg == QUOTE_SINGLE) && (c == CH_SQUOTE)))
            begin
                quote_next = QUOTE_NONE;
            end
            keep = 1'b1;
        end
        else if (skip_reg && (c != CH_LF))
        begin
            keep = 1'b0;
        end
        else
        begin
            skip_next = 1'b0;
            if (c == CH_CR)
            begin
                keep = 1'b0;
            end
            else if ((c == CH_HASH) && after_sep)
            begin
                skip_next = 1'b1;
            end
            else
            begin
                if (((c == CH_DQUOTE) || (c == CH_SQUOTE)) && after_opener)
                begin
                    quote_next = (c == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
                end
                if (c == CH_LF)
                begin
                    cnt_base = '0;
                end
                keep = 1'b1;
            end
        end

        room     = (cnt_base < CNT_W'(PENDING_DEPTH));
        cnt_next = cnt_base;
        if (keep)
        begin
            if (blank)
            begin
                if (room)
                begin
                    cnt_next = cnt_base + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                cnt_next  = '0;
                prev_next = c;
                none_next = 1'b0;
            end
        end
    end

    assign need_write = keep && blank && room;
    assign want_push  = s_tlast || (keep && !blank);

    // blank slots are reused only once the sequencer has drained its flush
    assign s_tready = !(want_push && q_full) && !(need_write && !back_idle);
    assign accept   = s_tvalid && s_tready;

    assign q_push        = accept && want_push;
    assign q_cmd.data    = s_tlast ? '0 : c;
    assign q_cmd.flush_n = FLUSH_W'(cnt_base);
    assign q_cmd.done    = s_tlast;
    assign q_cmd.ovf     = ovf_reg;

    assign ram_we    = accept && need_write;
    assign ram_waddr = cnt_base[ADDR_W-1:0];
    assign ram_wdata = (c == CH_TAB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= QUOTE_NONE;
            esc_reg   <= 1'b0;
            skip_reg  <= 1'b0;
            prev_reg  <= '0;
            none_reg  <= 1'b1;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            skip_reg  <= skip_next;
            prev_reg  <= prev_next;
            none_reg  <= none_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[sv/ytc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytc_back
// Output sequencer: replays held blanks from the blank store, then the kept
// byte of each command, through a registered output stage.
// ----------------------------------------------------------------------------
module ytc_back #(
    parameter int PENDING_DEPTH = 32,
    parameter int ADDR_W        = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ytc_pkg::cmd_t     q_cmd,
    output logic              q_pop,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic              ram_rdata,
    output logic              idle,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [1:0]        m_tuser
);
    import ytc_pkg::*;

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_CHAR  = 2'd2;

    logic [1:0]        state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] odata_reg, odata_next;
    logic              olast_reg, olast_next;
    logic [1:0]        ouser_reg, ouser_next;

    logic              out_free;
    logic              load;

    assign out_free = !ovalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        odata_next = odata_reg;
        olast_next = olast_reg;
        ouser_next = ouser_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_cmd;
                    idx_next   = '0;
                    state_next = (q_cmd.flush_n == '0) ? ST_CHAR : ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    odata_next = ram_rdata ? CH_TAB : CH_SPACE;
                    olast_next = 1'b0;
                    ouser_next = {cur_reg.ovf, 1'b0};
                    idx_next   = idx_reg + CNT_W'(1);
                    if ((FLUSH_W'(idx_reg) + FLUSH_W'(1)) == cur_reg.flush_n)
                    begin
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    odata_next = cur_reg.data;
                    olast_next = 1'b1;
                    ouser_next = {cur_reg.ovf, cur_reg.done};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            ovalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    // read one entry ahead so the data register always matches idx_reg
    assign ram_raddr = idx_next[ADDR_W-1:0];
    assign idle      = (state_reg == ST_IDLE);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        ouser_reg <= ouser_next;
    end

endmodule

[sv/yaml_text_cleaner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaml_text_cleaner
// Streaming YAML cleaner: strips comments, carriage returns and trailing
// blanks from a byte stream.
// ----------------------------------------------------------------------------
// Input: one raw byte per s_* transaction; s_tlast marks the end of the text
// (the byte is then ignored). Output: one cleaned byte per m_* transaction;
// m_tlast marks the final byte caused by one input, m_tuser[0] marks the NUL
// that closes a text, m_tuser[1] is the sticky blank overflow flag.
// Bytes that are dropped or blanks that are held produce no output.
// A classifier takes one byte per cycle while s_tready is high and pushes
// commands into a two-entry queue; the sequencer picks each command up,
// replays its held blanks, then emits the byte itself. Sustained rate is set
// by the sequencer, which emits one output byte per cycle while m_tready
// allows and passes through idle between commands; the queue keeps filling.
// A blank that is to be held is accepted only while the sequencer and queue
// are idle, since the blank store is shared between held and flushing blanks.
// Reset clears all text state and the overflow flag; the blank store itself
// needs no clearing. When m_tready is low the output register holds and the
// queue fills, after which s_tready drops.
// ----------------------------------------------------------------------------
module yaml_text_cleaner #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // last_of_run
    output logic [1:0] m_tuser    // [1] whitespace_overflow, [0] text_done
);
    import ytc_pkg::*;

    localparam int ADDR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    cmd_t              push_cmd;
    cmd_t              pop_cmd;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              seq_idle;
    logic              back_idle;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    assign back_idle = seq_idle && q_empty;

    ytc_front #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .back_idle(back_idle),
        .q_full(q_full),
        .q_push(q_push),
        .q_cmd(push_cmd),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata)
    );

    ytc_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_cmd(push_cmd),
        .full(q_full),
        .pop(q_pop),
        .pop_cmd(pop_cmd),
        .empty(q_empty)
    );

    ytc_ram #(
        .WIDTH(1),
        .DEPTH(PENDING_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_blank_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    ytc_back #(
        .PENDING_DEPTH(PENDING_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_cmd(pop_cmd),
        .q_pop(q_pop),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata),
        .idle(seq_idle),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

endmodule
